// ===== design/scga_pkg.sv =====
// shared types, codes and constants of the spin chain greedy angle update block
// grid trig generator used at elaboration time; no dependencies
package scga_pkg;

    localparam int SITE_W   = 7;
    localparam int COORD_W  = 16;
    localparam int STATUS_W = 2;
    localparam int ANGLE_W  = 7;
    localparam int ENERGY_W = 37;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_CHANGED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_KEPT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd2;

    // command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic signed [COORD_W-1:0] Q14_ONE = 16'sd16384;

    // taylor series constants, Q2.30
    localparam int          TAYLOR_TERMS = 12;
    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [63:0] PI_Q30       = 64'd3373259426;

    // per-term divisors (2k)(2k+1) for sin and (2k-1)(2k) for cos
    localparam logic [63:0] SIN_DIV [1:TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };
    localparam logic [63:0] COS_DIV [1:TAYLOR_TERMS] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    // truncated taylor sum of cos or sin of a Q2.30 angle, rounded to Q1.14
    function automatic logic [COORD_W-1:0] trig_q14(input logic [63:0] ang,
                                                     input logic want_sin);
        logic [63:0]        sq;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        sq   = (ang * ang) >> 30;
        term = want_sin ? ang : Q30_ONE;
        sum  = signed'(term);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            if (want_sin)
                term = (term * sq) / SIN_DIV[k];
            else
                term = (term * sq) / COS_DIV[k];
            if ((k & 1) != 0)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = '0;
        if (sum > signed'(Q30_ONE))
            sum = signed'(Q30_ONE);
        rnd = (unsigned'(sum) + 64'd32768) >> 16;
        return rnd[COORD_W-1:0];
    endfunction

endpackage

// ===== design/scga_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module scga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/spin_chain_greedy_angle_update_core.sv =====
// top level of the spin chain greedy angle update block
// uses scga_pkg and scga_ram
//
// Keeps a chain of CHAIN_LENGTH planar spins (x,y in Q1.14) in one ram, ends fixed at
// (0,1) and (0,-1). A word with cmd update names an interior site; the block sums the
// two neighbour spins, then scans the ANGLE_STEPS+1 grid angles from -pi/2 to pi/2 and
// moves the spin to the angle of lowest neighbour energy if that is strictly lower than
// now (lowest index on ties). cmd load writes a saturated spin into the site. Sites 0 and
// CHAIN_LENGTH-1 and above are rejected. Every input word gives exactly one result word
// carrying status, the chosen angle index and the running chain energy (Q9.28, wraps
// mod 2^37), kept incrementally. One word is worked on at a time: in_stall is low only
// while the sequencer is idle. An update steps through three ram reads for the
// neighbourhood, the scan, a drain, a commit and a push; a load takes the same path with
// one load step in place of the scan, and a rejected site goes straight to the push. The
// result word appears as the block returns to idle, and an output stall holds the push.
// The single shared dot-product unit evaluates one grid angle per cycle in a three-stage
// pipe (table read, multiply-add, compare).
// After reset the block writes reset spins into every ram site, with in_stall high.
module spin_chain_greedy_angle_update_core
    import scga_pkg::*;
#(
    parameter int CHAIN_LENGTH = 128,
    parameter int ANGLE_STEPS  = 100
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [SITE_W-1:0]           site,
    input  logic signed [COORD_W-1:0]   load_x,
    input  logic signed [COORD_W-1:0]   load_y,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [STATUS_W-1:0]         status,
    output logic [ANGLE_W-1:0]          angle_index,
    output logic signed [ENERGY_W-1:0]  total_energy
);

    localparam int AW = $clog2(CHAIN_LENGTH);
    localparam int IW = $clog2(ANGLE_STEPS + 1);
    localparam int CW = (AW > SITE_W) ? AW : SITE_W;
    localparam int DOT_W = 34;

    localparam logic [AW-1:0] LAST_SITE = AW'(CHAIN_LENGTH - 1);
    localparam logic [CW-1:0] MAX_SITE  = CW'(CHAIN_LENGTH - 2);
    localparam logic [IW-1:0] LAST_IDX  = IW'(ANGLE_STEPS);
    localparam logic [63:0]   ANG_DIV   = 64'(2 * ANGLE_STEPS);
    localparam logic [63:0]   E_RST_MAG = 64'(2 * (CHAIN_LENGTH - 3)) << 28;
    localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(64'd0 - E_RST_MAG);

    // grid tables built at elaboration
    typedef logic signed [COORD_W-1:0] trig_tab_t [ANGLE_STEPS + 1];

    function automatic trig_tab_t build_tab(input logic want_sin);
        trig_tab_t         tab;
        longint            m;
        logic [63:0]       mag;
        logic [63:0]       ang;
        logic [COORD_W-1:0] v;
        for (int i = 0; i <= ANGLE_STEPS; i++)
        begin
            m   = 2 * longint'(i) - longint'(ANGLE_STEPS);
            mag = (m < 0) ? 64'(-m) : 64'(m);
            ang = (mag * PI_Q30) / ANG_DIV;
            v   = trig_q14(ang, want_sin);
            tab[i] = (want_sin && (m < 0)) ? -signed'(v) : signed'(v);
        end
        return tab;
    endfunction

    localparam trig_tab_t COS_TAB = build_tab(1'b0);
    localparam trig_tab_t SIN_TAB = build_tab(1'b1);

    function automatic logic signed [COORD_W-1:0] sat_q14(
        input logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        r = v;
        if (v > Q14_ONE)
            r = Q14_ONE;
        else if (v < -Q14_ONE)
            r = -Q14_ONE;
        return r;
    endfunction

    // one-hot sequencer
    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_RD0    = 11'b000_0000_0100,
        ST_RD1    = 11'b000_0000_1000,
        ST_RD2    = 11'b000_0001_0000,
        ST_RD3    = 11'b000_0010_0000,
        ST_SCAN   = 11'b000_0100_0000,
        ST_LOAD   = 11'b000_1000_0000,
        ST_DRAIN  = 11'b001_0000_0000,
        ST_COMMIT = 11'b010_0000_0000,
        ST_PUSH   = 11'b100_0000_0000
    } state_t;

    // what each word in the dot-product pipe stands for
    typedef enum logic [1:0] {
        KIND_CUR  = 2'd0,
        KIND_CAND = 2'd1,
        KIND_LOAD = 2'd2
    } kind_t;

    state_t state_reg, state_next;

    // control
    logic [AW-1:0]          clr_cnt_reg;
    logic [IW-1:0]          idx_reg;
    logic                   p1_valid_reg, p2_valid_reg;
    logic                   change_reg;
    logic                   out_valid_reg;
    logic [ENERGY_W-1:0]    energy_reg, energy_next;

    // payload
    logic                       cmd_reg;
    logic [AW-1:0]              site_reg;
    logic signed [COORD_W-1:0]  load_x_reg, load_y_reg;
    logic signed [COORD_W-1:0]  nb_x_reg, nb_y_reg;
    logic signed [COORD_W:0]    sx_reg, sy_reg;
    kind_t                      p1_kind_reg, p2_kind_reg;
    logic [IW-1:0]              p1_idx_reg, p2_idx_reg;
    logic signed [COORD_W-1:0]  b_x_reg, b_y_reg;
    logic signed [COORD_W-1:0]  p2_x_reg, p2_y_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic signed [DOT_W-1:0]    cur_reg, best_reg;
    logic [IW-1:0]              pick_reg;
    logic signed [COORD_W-1:0]  new_x_reg, new_y_reg;
    logic [STATUS_W-1:0]        res_status_reg;
    logic [ANGLE_W-1:0]         res_angle_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [ANGLE_W-1:0]         angle_index_reg;
    logic [ENERGY_W-1:0]        total_energy_reg;

    // ram
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [2*COORD_W-1:0]       ram_wdata, ram_rdata;
    logic signed [COORD_W-1:0]  rd_x, rd_y;

    // shared dot-product unit
    logic signed [2*COORD_W:0]  prod_x, prod_y;
    logic signed [DOT_W-1:0]    dot_next;
    logic signed [DOT_W:0]      gain;

    logic site_ok;
    logic accept_in;
    logic push_ok;
    logic clr_last;
    logic idx_last;
    logic issue;

    assign rd_x = signed'(ram_rdata[2*COORD_W-1:COORD_W]);
    assign rd_y = signed'(ram_rdata[COORD_W-1:0]);

    assign site_ok   = (site != '0) && (CW'(site) <= MAX_SITE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign push_ok   = !out_valid_reg || !out_stall;
    assign clr_last  = (clr_cnt_reg == LAST_SITE);
    assign idx_last  = (idx_reg == LAST_IDX);
    assign issue     = (state_reg == ST_RD3) || (state_reg == ST_SCAN)
                       || (state_reg == ST_LOAD);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = site_ok ? ST_RD0 : ST_PUSH;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = ST_RD3;
            ST_RD3:    state_next = (cmd_reg == CMD_LOAD) ? ST_LOAD : ST_SCAN;
            ST_SCAN:   if (idx_last) state_next = ST_DRAIN;
            ST_LOAD:   state_next = ST_DRAIN;
            ST_DRAIN:  if (!p1_valid_reg && !p2_valid_reg) state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_PUSH;
            ST_PUSH:   if (push_ok) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // ram ports: reset sweep and commit write, neighbourhood reads
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = site_reg;
        ram_wdata = {new_x_reg, new_y_reg};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            priority if (clr_cnt_reg == '0)
                ram_wdata = {16'sd0, Q14_ONE};
            else if (clr_last)
                ram_wdata = {16'sd0, -Q14_ONE};
            else
                ram_wdata = {Q14_ONE, 16'sd0};
        end
        else if (state_reg == ST_COMMIT)
        begin
            ram_we = change_reg;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_RD0:  ram_raddr = site_reg - AW'(1);
            ST_RD1:  ram_raddr = site_reg + AW'(1);
            default: ram_raddr = site_reg;
        endcase
    end

    scga_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (CHAIN_LENGTH)
    ) u_spin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // neighbour sum times candidate spin
    assign prod_x   = sx_reg * b_x_reg;
    assign prod_y   = sy_reg * b_y_reg;
    assign dot_next = DOT_W'(prod_x) + DOT_W'(prod_y);

    // energy drops by twice the gain in neighbour dot product
    assign gain        = (DOT_W+1)'(best_reg) - (DOT_W+1)'(cur_reg);
    assign energy_next = energy_reg - (ENERGY_W'(gain) <<< 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            idx_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            change_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            energy_reg    <= ENERGY_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);

            // angle counter, parks on the last grid index
            if (state_reg == ST_RD3)
                idx_reg <= '0;
            else if ((state_reg == ST_SCAN) && !idx_last)
                idx_reg <= idx_reg + IW'(1);

            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;

            // compare stage
            if (p2_valid_reg)
            begin
                unique case (p2_kind_reg)
                    KIND_CUR:  change_reg <= 1'b0;
                    KIND_CAND: if (dot_reg > best_reg) change_reg <= 1'b1;
                    KIND_LOAD: change_reg <= 1'b1;
                    default:   change_reg <= change_reg;
                endcase
            end

            if ((state_reg == ST_COMMIT) && change_reg)
                energy_reg <= energy_next;

            if ((state_reg == ST_PUSH) && push_ok)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            cmd_reg    <= cmd;
            site_reg   <= AW'(site);
            load_x_reg <= sat_q14(load_x);
            load_y_reg <= sat_q14(load_y);
            // a rejected site goes straight to the result
            res_status_reg <= STATUS_REJECT;
            res_angle_reg  <= '0;
        end

        if (state_reg == ST_RD1)
        begin
            nb_x_reg <= rd_x;
            nb_y_reg <= rd_y;
        end
        if (state_reg == ST_RD2)
        begin
            sx_reg <= (COORD_W+1)'(nb_x_reg) + (COORD_W+1)'(rd_x);
            sy_reg <= (COORD_W+1)'(nb_y_reg) + (COORD_W+1)'(rd_y);
        end

        // stage 1: operand select
        unique case (state_reg)
            ST_RD3:
            begin
                p1_kind_reg <= KIND_CUR;
                b_x_reg     <= rd_x;
                b_y_reg     <= rd_y;
            end
            ST_LOAD:
            begin
                p1_kind_reg <= KIND_LOAD;
                b_x_reg     <= load_x_reg;
                b_y_reg     <= load_y_reg;
            end
            default:
            begin
                p1_kind_reg <= KIND_CAND;
                b_x_reg     <= COS_TAB[idx_reg];
                b_y_reg     <= SIN_TAB[idx_reg];
            end
        endcase
        p1_idx_reg <= idx_reg;

        // stage 2: multiply-add
        p2_kind_reg <= p1_kind_reg;
        p2_idx_reg  <= p1_idx_reg;
        p2_x_reg    <= b_x_reg;
        p2_y_reg    <= b_y_reg;
        dot_reg     <= dot_next;

        // stage 3: keep the best strictly lower energy
        if (p2_valid_reg)
        begin
            unique case (p2_kind_reg)
                KIND_CUR:
                begin
                    cur_reg  <= dot_reg;
                    best_reg <= dot_reg;
                    pick_reg <= '0;
                end
                KIND_CAND:
                begin
                    if (dot_reg > best_reg)
                    begin
                        best_reg  <= dot_reg;
                        pick_reg  <= p2_idx_reg;
                        new_x_reg <= p2_x_reg;
                        new_y_reg <= p2_y_reg;
                    end
                end
                KIND_LOAD:
                begin
                    best_reg  <= dot_reg;
                    new_x_reg <= p2_x_reg;
                    new_y_reg <= p2_y_reg;
                end
                default:
                begin
                    best_reg <= best_reg;
                end
            endcase
        end

        if (state_reg == ST_COMMIT)
        begin
            if (change_reg)
                res_status_reg <= STATUS_CHANGED;
            else
                res_status_reg <= STATUS_KEPT;
            if (change_reg && (cmd_reg == CMD_UPDATE))
                res_angle_reg <= ANGLE_W'(pick_reg);
            else
                res_angle_reg <= '0;
        end

        if ((state_reg == ST_PUSH) && push_ok)
        begin
            status_reg       <= res_status_reg;
            angle_index_reg  <= res_angle_reg;
            total_energy_reg <= energy_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign angle_index  = angle_index_reg;
    assign total_energy = signed'(total_energy_reg);

endmodule

// ===== design/scga_checker.sv =====
// port-level checks for spin_chain_greedy_angle_update_core, attached by bind
// uses scga_pkg
module scga_checker
    import scga_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       cmd,
    input logic [SITE_W-1:0]          site,
    input logic signed [COORD_W-1:0]  load_x,
    input logic signed [COORD_W-1:0]  load_y,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [STATUS_W-1:0]        status,
    input logic [ANGLE_W-1:0]         angle_index,
    input logic signed [ENERGY_W-1:0] total_energy
);

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_CHANGED || status == STATUS_KEPT
                       || status == STATUS_REJECT))
        else $error("undefined status code");

    // an angle is reported only with a changed spin
    a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_CHANGED)) |-> (angle_index == '0))
        else $error("angle index set without a change");

    // one word in flight: input closes right after a word is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after accept");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
                                      && $stable(angle_index) && $stable(total_energy)))
        else $error("stalled result word changed");

endmodule

bind spin_chain_greedy_angle_update_core scga_checker u_scga_checker (.*);

// ===== verif/spin_chain_greedy_angle_update_checker.sv =====
// result checker for the spin chain greedy angle update core
// watches both channels, keeps its own copy of the chain, uses scga_pkg
module spin_chain_greedy_angle_update_checker
    import scga_pkg::*;
#(
    parameter int CHAIN_LENGTH = 128,
    parameter int ANGLE_STEPS  = 100
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        cmd,
    input  logic [SITE_W-1:0]           site,
    input  logic signed [COORD_W-1:0]   load_x,
    input  logic signed [COORD_W-1:0]   load_y,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [STATUS_W-1:0]         status,
    input  logic [ANGLE_W-1:0]          angle_index,
    input  logic signed [ENERGY_W-1:0]  total_energy,
    output int                          mismatch_count,
    output int                          awaiting
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ANGLE_W-1:0]  angle;
        logic [ENERGY_W-1:0] energy;
    } chain_result_t;

    longint              cos_grid [0:ANGLE_STEPS];
    longint              sin_grid [0:ANGLE_STEPS];
    longint              spin_x [0:CHAIN_LENGTH-1];
    longint              spin_y [0:CHAIN_LENGTH-1];
    logic [ENERGY_W-1:0] chain_sum;
    chain_result_t       results_due [$];
    int                  bad_results;
    int                  results_seen;

    // truncated taylor series in Q2.30, clamped to [0,1], rounded to Q1.14
    function automatic longint taylor_q14(input logic [63:0] ang, input bit odd);
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] div;
        longint      acc;
        sq   = (ang * ang) >> 30;
        term = odd ? ang : 64'd1 << 30;
        acc  = longint'(term);
        for (int k = 1; k <= 12; k++)
        begin
            div  = odd ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
            term = (term * sq) / div;
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (longint'(1) << 30))
            acc = longint'(1) << 30;
        return (acc + 32768) >>> 16;
    endfunction

    function automatic longint clamp_q14(input logic signed [COORD_W-1:0] raw);
        longint v;
        v = raw;
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v;
    endfunction

    function automatic void reset_chain();
        for (int i = 0; i < CHAIN_LENGTH; i++)
        begin
            spin_x[i] = 16384;
            spin_y[i] = 0;
        end
        spin_x[0]              = 0;
        spin_y[0]              = 16384;
        spin_x[CHAIN_LENGTH-1] = 0;
        spin_y[CHAIN_LENGTH-1] = -16384;
        chain_sum = ENERGY_W'(-(longint'(2 * (CHAIN_LENGTH - 3)) << 28));
    endfunction

    // applies one input word to the chain copy and returns the result it gives
    function automatic chain_result_t apply_word(input logic c, input logic [SITE_W-1:0] s,
                                                 input logic signed [COORD_W-1:0] lx,
                                                 input logic signed [COORD_W-1:0] ly);
        longint        sx;
        longint        sy;
        longint        cur;
        longint        best;
        longint        d;
        longint        nx;
        longint        ny;
        int            pick;
        bit            moved;
        chain_result_t r;
        r        = '0;
        r.status = STATUS_CHANGED;
        if (s == 0 || s > CHAIN_LENGTH - 2)
            r.status = STATUS_REJECT;
        else
        begin
            sx    = spin_x[s-1] + spin_x[s+1];
            sy    = spin_y[s-1] + spin_y[s+1];
            cur   = sx * spin_x[s] + sy * spin_y[s];
            best  = cur;
            moved = 1'b0;
            pick  = -1;
            nx    = 0;
            ny    = 0;
            if (c == CMD_LOAD)
            begin
                nx    = clamp_q14(lx);
                ny    = clamp_q14(ly);
                best  = sx * nx + sy * ny;
                moved = 1'b1;
            end
            else
            begin
                for (int i = 0; i <= ANGLE_STEPS; i++)
                begin
                    d = sx * cos_grid[i] + sy * sin_grid[i];
                    if (d > best)
                    begin
                        best = d;
                        pick = i;
                    end
                end
                if (pick >= 0)
                begin
                    nx      = cos_grid[pick];
                    ny      = sin_grid[pick];
                    r.angle = ANGLE_W'(pick);
                    moved   = 1'b1;
                end
                else
                    r.status = STATUS_KEPT;
            end
            if (moved)
            begin
                spin_x[s] = nx;
                spin_y[s] = ny;
                chain_sum = chain_sum + ENERGY_W'(-2 * (best - cur));
            end
        end
        r.energy = chain_sum;
        return r;
    endfunction

    initial
    begin : build_grid
        logic [63:0] offset;
        logic [63:0] ang;
        longint      s;
        for (int i = 0; i <= ANGLE_STEPS; i++)
        begin
            offset = (2 * i >= ANGLE_STEPS) ? 64'(2 * i - ANGLE_STEPS)
                                            : 64'(ANGLE_STEPS - 2 * i);
            ang         = (offset * PI_Q30) / 64'(2 * ANGLE_STEPS);
            cos_grid[i] = taylor_q14(ang, 1'b0);
            s           = taylor_q14(ang, 1'b1);
            sin_grid[i] = (2 * i < ANGLE_STEPS) ? -s : s;
        end
    end

    always @(posedge clk)
    begin : watch
        chain_result_t want;
        if (!rst_n)
        begin
            reset_chain();
            results_due.delete();
        end
        else
        begin
            // outputs first: a word taken this edge cannot be answered this edge
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    if (bad_results < 10)
                        $display("unexpected result %0d: status %0d angle %0d energy %0d",
                                 results_seen, status, angle_index, total_energy);
                    bad_results++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status || angle_index !== want.angle ||
                        total_energy !== $signed(want.energy))
                    begin
                        if (bad_results < 10)
                            $display("result %0d: expected status %0d angle %0d energy %0d,",
                                     results_seen, want.status, want.angle,
                                     $signed(want.energy),
                                     " got status %0d angle %0d energy %0d",
                                     status, angle_index, total_energy);
                        bad_results++;
                    end
                end
            end
            if (in_valid && !in_stall)
                results_due.push_back(apply_word(cmd, site, load_x, load_y));
        end
        awaiting       <= results_due.size();
        mismatch_count <= bad_results;
    end

endmodule

// ===== verif/spin_chain_greedy_angle_update_core_test.sv =====
// testbench top for the spin chain greedy angle update core
// drives stimulus and stalls, gives the verdict; uses scga_pkg and the checker module
module spin_chain_greedy_angle_update_core_test
    import scga_pkg::*;
();

    localparam int CHAIN_LENGTH  = 128;
    localparam int ANGLE_STEPS   = 100;
    localparam int HALF_PERIOD   = 5;
    localparam int WORD_TARGET   = 950;
    localparam int LONG_HOLD     = 600;   // long output hold, well past one update
    localparam int SETTLE_CYCLES = 200;   // longer than the slowest update
    localparam int LAST_SITE     = CHAIN_LENGTH - 2;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       cmd;
    logic [SITE_W-1:0]          site;
    logic signed [COORD_W-1:0]  load_x;
    logic signed [COORD_W-1:0]  load_y;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic [ANGLE_W-1:0]         angle_index;
    logic signed [ENERGY_W-1:0] total_energy;

    int mismatch_count;
    int awaiting;
    int burst_left;
    int words_sent;
    bit hold_off_req;

    spin_chain_greedy_angle_update_core #(
        .CHAIN_LENGTH (CHAIN_LENGTH),
        .ANGLE_STEPS  (ANGLE_STEPS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .site         (site),
        .load_x       (load_x),
        .load_y       (load_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .angle_index  (angle_index),
        .total_energy (total_energy)
    );

    // prediction and comparison live in the checker; it reports a failure count
    spin_chain_greedy_angle_update_checker #(
        .CHAIN_LENGTH (CHAIN_LENGTH),
        .ANGLE_STEPS  (ANGLE_STEPS)
    ) chain_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .site           (site),
        .load_x         (load_x),
        .load_y         (load_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .angle_index    (angle_index),
        .total_energy   (total_energy),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    initial
        clk = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    // spin component, weighted toward saturation limits and exact unit values
    function automatic logic [COORD_W-1:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word and wait until it is taken; the sender runs in bursts,
    // a burst ends with valid low for a random gap so gaps land on every
    // phase of the block's scan
    task automatic offer_word(input logic c, input logic [SITE_W-1:0] s,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 30))
                @(posedge clk);
            // mostly short bursts, sometimes long back-to-back stretches
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        site     <= s;
        load_x   <= x;
        load_y   <= y;
        // in_stall read right after the edge is the value the edge saw
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // receiver: random stall modes over random stretches, plus one long hold
    // that lets the block fill and push back on the sender
    initial
    begin : receiver
        int stretch;
        int mode;
        int hold_cycles;
        out_stall   = 1'b0;
        stretch     = 0;
        mode        = 0;
        hold_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_cycles  = LONG_HOLD - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch = $urandom_range(20, 400);
                    mode    = $urandom_range(0, 3);
                end
                stretch--;
                case (mode)
                    0: out_stall <= 1'b0;                          // never stall
                    1: out_stall <= ($urandom_range(0, 3) == 0);   // light
                    2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy
                    default: out_stall <= ~out_stall;              // alternating
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int          kind;
        int          first;
        int          span;
        int          idx;
        int          at;
        bit          climbing;
        bit          alternate;
        logic [15:0] vx;
        logic [15:0] vy;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_UPDATE;
        site         = '0;
        load_x       = '0;
        load_y       = '0;
        burst_left   = 0;
        words_sent   = 0;
        hold_off_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // rejected sites: zero and the fixed last site, for both commands
        offer_word(CMD_UPDATE, SITE_W'(0), 16'h1234, 16'hfedc);
        offer_word(CMD_UPDATE, SITE_W'(CHAIN_LENGTH - 1), 16'h0000, 16'hffff);
        offer_word(CMD_LOAD, SITE_W'(0), 16'h7fff, 16'h8000);
        offer_word(CMD_LOAD, SITE_W'(CHAIN_LENGTH - 1), 16'h4000, 16'h4000);
        // first interior site next to the fixed up spin, then again: should keep
        offer_word(CMD_UPDATE, SITE_W'(1), 16'hffff, 16'h0000);
        offer_word(CMD_UPDATE, SITE_W'(1), 16'h0000, 16'hffff);
        // aligned neighbours: already at the best angle, nothing lower
        offer_word(CMD_UPDATE, SITE_W'(64), 16'h0000, 16'h0000);
        // both neighbours up: best angle is pi/2, the top grid index
        offer_word(CMD_LOAD, SITE_W'(2), 16'h0000, 16'h4000);
        offer_word(CMD_UPDATE, SITE_W'(1), 16'h5555, 16'haaaa);
        // both neighbours down: best angle is -pi/2, grid index zero
        offer_word(CMD_LOAD, SITE_W'(125), 16'h0000, 16'hc000);
        offer_word(CMD_UPDATE, SITE_W'(LAST_SITE), 16'haaaa, 16'h5555);
        // loads past full scale saturate
        offer_word(CMD_LOAD, SITE_W'(64), 16'h7fff, 16'h8000);
        offer_word(CMD_LOAD, SITE_W'(64), 16'h8000, 16'h7fff);
        offer_word(CMD_LOAD, SITE_W'(64), 16'h4001, 16'hbfff);
        offer_word(CMD_UPDATE, SITE_W'(63), 16'h0000, 16'h0000);
        offer_word(CMD_UPDATE, SITE_W'(65), 16'h0000, 16'h0000);
        offer_word(CMD_UPDATE, SITE_W'(64), 16'h0000, 16'h0000);
        // load of the spin already there still counts as a change
        offer_word(CMD_LOAD, SITE_W'(20), 16'h4000, 16'h0000);
        // opposite neighbours cancel: every angle ties, spin stays
        offer_word(CMD_LOAD, SITE_W'(99), 16'hc000, 16'h0000);
        offer_word(CMD_LOAD, SITE_W'(101), 16'h4000, 16'h0000);
        offer_word(CMD_UPDATE, SITE_W'(100), 16'h0000, 16'h0000);
        // zero spin and a neighbour of it
        offer_word(CMD_LOAD, SITE_W'(10), 16'h0000, 16'h0000);
        offer_word(CMD_UPDATE, SITE_W'(11), 16'h0000, 16'h0000);
        offer_word(CMD_UPDATE, SITE_W'(10), 16'h0000, 16'h0000);
        offer_word(CMD_LOAD, SITE_W'(50), 16'hffff, 16'h0001);

        // long output hold while the sender keeps offering words
        hold_off_req = 1'b1;

        // fill the whole chain with oversized spins: energy wraps negative
        for (idx = 1; idx <= LAST_SITE; idx++)
            offer_word(CMD_LOAD, SITE_W'(idx), Q14_ONE, Q14_ONE);

        while (words_sent < WORD_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // sweep of updates over neighbouring sites, either direction
                first    = $urandom_range(1, LAST_SITE);
                span     = $urandom_range(1, 30);
                climbing = $urandom_range(0, 1);
                idx      = 0;
                at       = first;
                while (idx < span && at >= 1 && at <= LAST_SITE)
                begin
                    offer_word(CMD_UPDATE, SITE_W'(at), 16'($urandom), 16'($urandom));
                    idx++;
                    at = climbing ? first + idx : first - idx;
                end
            end
            else if (kind < 60)
            begin
                // scattered updates
                span = $urandom_range(1, 6);
                for (idx = 0; idx < span; idx++)
                    offer_word(CMD_UPDATE, SITE_W'($urandom_range(1, LAST_SITE)),
                               16'($urandom), 16'($urandom));
            end
            else if (kind < 75)
            begin
                // run of loads with one vector, optionally alternating sign;
                // long runs of large spins drive the energy past its range
                first     = $urandom_range(1, LAST_SITE);
                span      = $urandom_range(1, 40);
                alternate = $urandom_range(0, 1);
                vx        = pick_component();
                vy        = pick_component();
                idx       = 0;
                while (idx < span && first + idx <= LAST_SITE)
                begin
                    if (alternate && idx % 2 == 1)
                        offer_word(CMD_LOAD, SITE_W'(first + idx), -vx, -vy);
                    else
                        offer_word(CMD_LOAD, SITE_W'(first + idx), vx, vy);
                    idx++;
                end
            end
            else if (kind < 87)
                // single load with raw random components
                offer_word(CMD_LOAD, SITE_W'($urandom_range(1, LAST_SITE)),
                           16'($urandom), 16'($urandom));
            else if (kind < 94)
                // bad site with either command
                offer_word(1'($urandom),
                           $urandom_range(0, 1) ? SITE_W'(0) : SITE_W'(CHAIN_LENGTH - 1),
                           16'($urandom), 16'($urandom));
            else
                // anything at all
                offer_word(1'($urandom), SITE_W'($urandom), 16'($urandom), 16'($urandom));
        end
        in_valid <= 1'b0;

        // drain, then give a stray extra result time to show up
        do
            @(posedge clk);
        while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit, several times the slowest expected run
    initial
    begin : watchdog
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
